@@ hdl/sgpf_pkg.sv @@
// Package: widths, payload structs and register codes of the sepia/grayscale pixel filter.
`timescale 1ns / 1ps

package sgpf_pkg;

   localparam int PIX_W      = 8;
   localparam int POS_W      = 12;
   localparam int BOUND_W    = 13;
   localparam int MAX_DIM    = 4096;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   typedef struct packed {
      logic [PIX_W-1:0] red_in;
      logic [PIX_W-1:0] green_in;
      logic [PIX_W-1:0] blue_in;
      logic [POS_W-1:0] pixel_col;
      logic [POS_W-1:0] pixel_row;
   } pixel_req_type;

   typedef struct packed {
      logic [PIX_W-1:0] red_out;
      logic [PIX_W-1:0] green_out;
      logic [PIX_W-1:0] blue_out;
      logic             was_filtered;
   } pixel_rsp_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FILTER_KIND    = 3'd0,
      CSR_IMAGE_IS_COLOR = 3'd1,
      CSR_MAX_LEVEL      = 3'd2,
      CSR_SEL_LEFT       = 3'd3,
      CSR_SEL_RIGHT      = 3'd4,
      CSR_SEL_TOP        = 3'd5,
      CSR_SEL_BOTTOM     = 3'd6
   } csr_reg_type;

   typedef enum logic {
      FILTER_SEPIA = 1'b0,
      FILTER_GRAY  = 1'b1
   } filter_kind_type;

endpackage

@@ hdl/sepia_grayscale_pixel_filter_unit.sv @@
// Streaming sepia / grayscale pixel filter with selection window and register port.
// Takes one pixel per clock and returns one result per pixel while rsp_ready does not stall
// the output. The work runs through a four-stage pipeline: constant products and window
// test, channel sums with rounding bias, reciprocal multiplies for the divisions by 1000
// and by 3, then clamp and select into the output register. A stalled output holds each
// occupied stage whose later stages are all occupied; other stages still advance and fill.
// Registers are written through the csr_ port, which is always ready; the user must write
// them only while no pixel is in flight, as the block itself does not enforce this.
`timescale 1ns / 1ps

module sepia_grayscale_pixel_filter_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  sgpf_pkg::pixel_req_type              req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output sgpf_pkg::pixel_rsp_type              rsp_payload,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sgpf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [sgpf_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int COEF_W       = 10;
   localparam int PROD_W       = 18;
   localparam int SUM_W        = 19;
   localparam int GSUM_W       = 10;
   localparam int QPROD_W      = 2 * SUM_W;
   localparam int GPROD_W      = 2 * GSUM_W;
   localparam int QUOT_W       = 10;
   localparam int RECIP_SHIFT  = 28;
   localparam int RECIP3_SHIFT = 11;
   localparam int PW           = sgpf_pkg::PIX_W;

   localparam logic [COEF_W-1:0] SEPIA_COEF [3][3] = '{
      '{10'd393, 10'd769, 10'd189},
      '{10'd349, 10'd686, 10'd168},
      '{10'd272, 10'd534, 10'd131}
   };
   localparam logic [SUM_W-1:0]  ROUND_BIAS = 19'd500;
   localparam logic [SUM_W-1:0]  RECIP_1000 = 19'd268436;
   localparam logic [GSUM_W-1:0] RECIP_3    = 10'd683;

   // configuration registers
   logic                         filter_kind_ff;
   logic                         image_is_color_ff;
   logic [PW-1:0]                max_level_ff;
   logic [sgpf_pkg::BOUND_W-1:0] sel_left_ff;
   logic [sgpf_pkg::BOUND_W-1:0] sel_right_ff;
   logic [sgpf_pkg::BOUND_W-1:0] sel_top_ff;
   logic [sgpf_pkg::BOUND_W-1:0] sel_bottom_ff;

   // stage valids and enables
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic en1, en2, en3, en4;

   // stage 1
   logic [PW-1:0]     pix_in [3];
   logic [PROD_W-1:0] prod_in [3][3];
   logic [PROD_W-1:0] prod_ff [3][3];
   logic [GSUM_W-1:0] gsum_in, gsum1_ff;
   logic              active_in, active1_ff;
   logic              kind1_ff;
   logic [PW-1:0]     pix1_ff [3];

   // stage 2
   logic [SUM_W-1:0]  sum_in [3];
   logic [SUM_W-1:0]  sum_ff [3];
   logic [GSUM_W-1:0] gsum2_ff;
   logic              active2_ff, kind2_ff;
   logic [PW-1:0]     pix2_ff [3];

   // stage 3
   logic [QPROD_W-1:0] qprod_in [3];
   logic [QPROD_W-1:0] qprod_ff [3];
   logic [GPROD_W-1:0] gprod_in, gprod_ff;
   logic               active3_ff, kind3_ff;
   logic [PW-1:0]      pix3_ff [3];

   // stage 4 (output)
   logic [QUOT_W-1:0]       quot [3];
   logic [PW-1:0]           tone [3];
   logic [PW-1:0]           gray;
   sgpf_pkg::pixel_rsp_type rsp_in, rsp_ff;
   logic                    kind4_ff;

   assign en4       = !s4_valid_ff || rsp_ready;
   assign en3       = !s3_valid_ff || en4;
   assign en2       = !s2_valid_ff || en3;
   assign en1       = !s1_valid_ff || en2;
   assign req_ready = en1;
   assign csr_ready = 1'b1;
   assign rsp_valid = s4_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_kind_ff    <= sgpf_pkg::FILTER_SEPIA;
         image_is_color_ff <= 1'b1;
         max_level_ff      <= 8'd255;
         sel_left_ff       <= '0;
         sel_right_ff      <= sgpf_pkg::BOUND_W'(sgpf_pkg::MAX_DIM);
         sel_top_ff        <= '0;
         sel_bottom_ff     <= sgpf_pkg::BOUND_W'(sgpf_pkg::MAX_DIM);
      end else if (csr_valid) begin
         unique case (sgpf_pkg::csr_reg_type'(csr_index))
            sgpf_pkg::CSR_FILTER_KIND:    filter_kind_ff    <= csr_data[0];
            sgpf_pkg::CSR_IMAGE_IS_COLOR: image_is_color_ff <= csr_data[0];
            sgpf_pkg::CSR_MAX_LEVEL:      max_level_ff      <= csr_data[PW-1:0];
            sgpf_pkg::CSR_SEL_LEFT:       sel_left_ff       <= csr_data;
            sgpf_pkg::CSR_SEL_RIGHT:      sel_right_ff      <= csr_data;
            sgpf_pkg::CSR_SEL_TOP:        sel_top_ff        <= csr_data;
            sgpf_pkg::CSR_SEL_BOTTOM:     sel_bottom_ff     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      pix_in[0] = req_payload.red_in;
      pix_in[1] = req_payload.green_in;
      pix_in[2] = req_payload.blue_in;
      for (int c = 0; c < 3; c++) begin
         for (int k = 0; k < 3; k++) begin
            prod_in[c][k] = PROD_W'(SEPIA_COEF[c][k]) * PROD_W'(pix_in[k]);
         end
      end
      gsum_in = GSUM_W'(pix_in[0]) + GSUM_W'(pix_in[1]) + GSUM_W'(pix_in[2]);
      active_in = image_is_color_ff
               && ({1'b0, req_payload.pixel_col} >= sel_left_ff)
               && ({1'b0, req_payload.pixel_col} <  sel_right_ff)
               && ({1'b0, req_payload.pixel_row} >= sel_top_ff)
               && ({1'b0, req_payload.pixel_row} <  sel_bottom_ff);
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sum_in[c] = SUM_W'(prod_ff[c][0]) + SUM_W'(prod_ff[c][1])
                   + SUM_W'(prod_ff[c][2]) + ROUND_BIAS;
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         qprod_in[c] = QPROD_W'(sum_ff[c]) * QPROD_W'(RECIP_1000);
      end
      gprod_in = GPROD_W'(gsum2_ff) * GPROD_W'(RECIP_3);
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         quot[c] = qprod_ff[c][RECIP_SHIFT +: QUOT_W];
         tone[c] = (quot[c] > QUOT_W'(max_level_ff)) ? max_level_ff : quot[c][PW-1:0];
      end
      gray = gprod_ff[RECIP3_SHIFT +: PW];
      rsp_in.was_filtered = active3_ff;
      if (!active3_ff) begin
         rsp_in.red_out   = pix3_ff[0];
         rsp_in.green_out = pix3_ff[1];
         rsp_in.blue_out  = pix3_ff[2];
      end else if (kind3_ff == sgpf_pkg::FILTER_GRAY) begin
         rsp_in.red_out   = gray;
         rsp_in.green_out = gray;
         rsp_in.blue_out  = gray;
      end else begin
         rsp_in.red_out   = tone[0];
         rsp_in.green_out = tone[1];
         rsp_in.blue_out  = tone[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_valid_ff <= req_valid;
         if (en2) s2_valid_ff <= s1_valid_ff;
         if (en3) s3_valid_ff <= s2_valid_ff;
         if (en4) s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         prod_ff    <= prod_in;
         gsum1_ff   <= gsum_in;
         active1_ff <= active_in;
         kind1_ff   <= filter_kind_ff;
         pix1_ff    <= pix_in;
      end
      if (en2) begin
         sum_ff     <= sum_in;
         gsum2_ff   <= gsum1_ff;
         active2_ff <= active1_ff;
         kind2_ff   <= kind1_ff;
         pix2_ff    <= pix1_ff;
      end
      if (en3) begin
         qprod_ff   <= qprod_in;
         gprod_ff   <= gprod_in;
         active3_ff <= active2_ff;
         kind3_ff   <= kind2_ff;
         pix3_ff    <= pix2_ff;
      end
      if (en4) begin
         rsp_ff     <= rsp_in;
         kind4_ff   <= kind3_ff;
      end
   end

`ifndef ASSERT_OFF
   a_gray_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.was_filtered && kind4_ff == sgpf_pkg::FILTER_GRAY
      |-> rsp_payload.red_out == rsp_payload.green_out
          && rsp_payload.green_out == rsp_payload.blue_out)
      else $error("grayscale result channels differ");

   a_sepia_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.was_filtered && kind4_ff == sgpf_pkg::FILTER_SEPIA
      |-> rsp_payload.red_out <= max_level_ff && rsp_payload.green_out <= max_level_ff
          && rsp_payload.blue_out <= max_level_ff)
      else $error("sepia result above max_level");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_valid_ff)
      else $error("accepted transaction not captured in first stage");

   a_stage3_hold: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && !en3 |=> s3_valid_ff && $stable(active3_ff) && $stable(gprod_ff))
      else $error("stalled stage lost its transaction");
`endif

endmodule

@@ sim/tb.sv @@
// Testbench: directed table and randomized pixel stream checked against a sepia/grayscale predictor.
`timescale 1ns / 1ps

module tb;

   localparam int HOLD_CYCLES  = 150;
   localparam int DRAIN_CYCLES = 8;
   localparam int PHASE_ITEMS  = 300;
   localparam logic [sgpf_pkg::CSR_IDX_W-1:0] CSR_SPARE_IDX = 3'd7;

   typedef enum logic {ROW_PIXEL, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type                    kind;
      logic [sgpf_pkg::CSR_IDX_W-1:0]  idx;
      logic [sgpf_pkg::CSR_DATA_W-1:0] data;
      sgpf_pkg::pixel_req_type         px;
      bit                              known;
      sgpf_pkg::pixel_rsp_type         want;
   } stim_row_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   sgpf_pkg::pixel_req_type         req_payload;
   logic                            rsp_valid;
   logic                            rsp_ready;
   sgpf_pkg::pixel_rsp_type         rsp_payload;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [sgpf_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [sgpf_pkg::CSR_DATA_W-1:0] csr_data;

   sgpf_pkg::filter_kind_type       cfg_filter;
   logic                            cfg_color;
   logic [sgpf_pkg::PIX_W-1:0]      cfg_max;
   logic [sgpf_pkg::BOUND_W-1:0]    cfg_left;
   logic [sgpf_pkg::BOUND_W-1:0]    cfg_right;
   logic [sgpf_pkg::BOUND_W-1:0]    cfg_top;
   logic [sgpf_pkg::BOUND_W-1:0]    cfg_bottom;

   sgpf_pkg::pixel_rsp_type         awaited_pixels[$];
   sgpf_pkg::pixel_rsp_type         oldest_pixel;
   stim_row_type                    stim_table[$];
   int unsigned                     send_pcts[4]  = '{0, 84, 0, 38};
   int unsigned                     stall_pcts[4] = '{0, 0, 84, 38};
   int unsigned                     send_idle_pct = 0;
   int unsigned                     recv_stall_pct = 0;
   int                              hold_requests = 0;
   int                              hold_seen = 0;
   int                              hold_left = 0;
   int                              mismatch_count = 0;
   int                              results_seen = 0;

   sepia_grayscale_pixel_filter_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [sgpf_pkg::PIX_W-1:0] sepia_channel(
         input sgpf_pkg::pixel_req_type px, input int unsigned kr,
         input int unsigned kg, input int unsigned kb);
      int unsigned mix;
      mix = (kr * px.red_in + kg * px.green_in + kb * px.blue_in + 500) / 1000;
      if (mix > cfg_max) mix = cfg_max;
      return mix[sgpf_pkg::PIX_W-1:0];
   endfunction

   function automatic sgpf_pkg::pixel_rsp_type filter_pixel(input sgpf_pkg::pixel_req_type px);
      int unsigned             col;
      int unsigned             row;
      int unsigned             gray;
      bit                      in_window;
      sgpf_pkg::pixel_rsp_type res;
      col = px.pixel_col;
      row = px.pixel_row;
      in_window = col >= cfg_left && col < cfg_right && row >= cfg_top && row < cfg_bottom;
      res.red_out      = px.red_in;
      res.green_out    = px.green_in;
      res.blue_out     = px.blue_in;
      res.was_filtered = cfg_color && in_window;
      if (res.was_filtered) begin
         if (cfg_filter == sgpf_pkg::FILTER_SEPIA) begin
            res.red_out   = sepia_channel(px, 393, 769, 189);
            res.green_out = sepia_channel(px, 349, 686, 168);
            res.blue_out  = sepia_channel(px, 272, 534, 131);
         end else begin
            gray = (int'(px.red_in) + int'(px.green_in) + int'(px.blue_in)) / 3;
            res.red_out   = gray[sgpf_pkg::PIX_W-1:0];
            res.green_out = gray[sgpf_pkg::PIX_W-1:0];
            res.blue_out  = gray[sgpf_pkg::PIX_W-1:0];
         end
      end
      return res;
   endfunction

   function automatic stim_row_type pixel_row(input int r, input int g, input int b,
                                              input int c, input int w);
      stim_row_type row;
      row.kind         = ROW_PIXEL;
      row.idx          = '0;
      row.data         = '0;
      row.px.red_in    = sgpf_pkg::PIX_W'(r);
      row.px.green_in  = sgpf_pkg::PIX_W'(g);
      row.px.blue_in   = sgpf_pkg::PIX_W'(b);
      row.px.pixel_col = sgpf_pkg::POS_W'(c);
      row.px.pixel_row = sgpf_pkg::POS_W'(w);
      row.known        = 1'b0;
      row.want         = '0;
      return row;
   endfunction

   function automatic stim_row_type known_row(input int r, input int g, input int b,
                                              input int c, input int w, input int er,
                                              input int eg, input int eb, input int ef);
      stim_row_type row;
      row                   = pixel_row(r, g, b, c, w);
      row.known             = 1'b1;
      row.want.red_out      = sgpf_pkg::PIX_W'(er);
      row.want.green_out    = sgpf_pkg::PIX_W'(eg);
      row.want.blue_out     = sgpf_pkg::PIX_W'(eb);
      row.want.was_filtered = ef[0];
      return row;
   endfunction

   function automatic stim_row_type csr_row(input logic [sgpf_pkg::CSR_IDX_W-1:0] idx,
                                            input int data);
      stim_row_type row;
      row      = pixel_row(0, 0, 0, 0, 0);
      row.kind = ROW_CSR;
      row.idx  = idx;
      row.data = sgpf_pkg::CSR_DATA_W'(data);
      return row;
   endfunction

   function automatic logic [sgpf_pkg::POS_W-1:0] pick_coord(input int unsigned lo,
                                                             input int unsigned hi);
      int unsigned v;
      case ($urandom_range(5))
         0: v = lo;
         1: v = lo - 1;
         2: v = hi;
         3: v = hi - 1;
         default: v = $urandom_range(sgpf_pkg::MAX_DIM - 1);
      endcase
      return v[sgpf_pkg::POS_W-1:0];
   endfunction

   function automatic logic [sgpf_pkg::PIX_W-1:0] pick_sample();
      case ($urandom_range(7))
         0: return 8'd0;
         1: return 8'd255;
         default: return sgpf_pkg::PIX_W'($urandom_range(255));
      endcase
   endfunction

   task automatic flag_mismatch(input string what);
      $display("mismatch at result %0d: %s", results_seen, what);
      mismatch_count++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (awaited_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic send_pixel(input sgpf_pkg::pixel_req_type px, input bit known,
                             input sgpf_pkg::pixel_rsp_type known_rsp);
      csr_valid <= 1'b0;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= px;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      awaited_pixels.push_back(known ? known_rsp : filter_pixel(px));
   endtask

   task automatic write_csr(input logic [sgpf_pkg::CSR_IDX_W-1:0] idx, input int unsigned data);
      wait_for_results();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data[sgpf_pkg::CSR_DATA_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         sgpf_pkg::CSR_FILTER_KIND:    cfg_filter = sgpf_pkg::filter_kind_type'(data[0]);
         sgpf_pkg::CSR_IMAGE_IS_COLOR: cfg_color  = data[0];
         sgpf_pkg::CSR_MAX_LEVEL:      cfg_max    = data[sgpf_pkg::PIX_W-1:0];
         sgpf_pkg::CSR_SEL_LEFT:       cfg_left   = data[sgpf_pkg::BOUND_W-1:0];
         sgpf_pkg::CSR_SEL_RIGHT:      cfg_right  = data[sgpf_pkg::BOUND_W-1:0];
         sgpf_pkg::CSR_SEL_TOP:        cfg_top    = data[sgpf_pkg::BOUND_W-1:0];
         sgpf_pkg::CSR_SEL_BOTTOM:     cfg_bottom = data[sgpf_pkg::BOUND_W-1:0];
         default: ;
      endcase
   endtask

   task automatic shuffle_settings();
      int unsigned a;
      int unsigned b;
      int unsigned c;
      int unsigned d;
      if ($urandom_range(1))
         write_csr(sgpf_pkg::CSR_FILTER_KIND, ($urandom_range(4095) << 1) | $urandom_range(1));
      if ($urandom_range(1))
         write_csr(sgpf_pkg::CSR_IMAGE_IS_COLOR,
                   ($urandom_range(4095) << 1) | ($urandom_range(4) != 0));
      if ($urandom_range(1)) begin
         case ($urandom_range(4))
            0: write_csr(sgpf_pkg::CSR_MAX_LEVEL, 255);
            1: write_csr(sgpf_pkg::CSR_MAX_LEVEL, 1);
            2: write_csr(sgpf_pkg::CSR_MAX_LEVEL, 0);
            default: write_csr(sgpf_pkg::CSR_MAX_LEVEL,
                               ($urandom_range(31) << 8) | $urandom_range(255));
         endcase
      end
      case ($urandom_range(7))
         0: begin
            a = 0;
            b = sgpf_pkg::MAX_DIM;
            c = 0;
            d = sgpf_pkg::MAX_DIM;
         end
         1: begin
            a = $urandom_range(8191);
            b = $urandom_range(8191);
            c = $urandom_range(8191);
            d = $urandom_range(8191);
         end
         default: begin
            a = $urandom_range(sgpf_pkg::MAX_DIM);
            b = $urandom_range(sgpf_pkg::MAX_DIM);
            c = $urandom_range(sgpf_pkg::MAX_DIM);
            d = $urandom_range(sgpf_pkg::MAX_DIM);
            if (a > b) {a, b} = {b, a};
            if (c > d) {c, d} = {d, c};
         end
      endcase
      write_csr(sgpf_pkg::CSR_SEL_LEFT, a);
      write_csr(sgpf_pkg::CSR_SEL_RIGHT, b);
      write_csr(sgpf_pkg::CSR_SEL_TOP, c);
      write_csr(sgpf_pkg::CSR_SEL_BOTTOM, d);
      if ($urandom_range(9) == 0) write_csr(CSR_SPARE_IDX, $urandom_range(8191));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_pixels.size() == 0) begin
               flag_mismatch("result with no pixel awaited");
            end else begin
               oldest_pixel = awaited_pixels.pop_front();
               if (rsp_payload.red_out !== oldest_pixel.red_out)
                  flag_mismatch($sformatf("red_out got %0d want %0d",
                                          rsp_payload.red_out, oldest_pixel.red_out));
               if (rsp_payload.green_out !== oldest_pixel.green_out)
                  flag_mismatch($sformatf("green_out got %0d want %0d",
                                          rsp_payload.green_out, oldest_pixel.green_out));
               if (rsp_payload.blue_out !== oldest_pixel.blue_out)
                  flag_mismatch($sformatf("blue_out got %0d want %0d",
                                          rsp_payload.blue_out, oldest_pixel.blue_out));
               if (rsp_payload.was_filtered !== oldest_pixel.was_filtered)
                  flag_mismatch($sformatf("was_filtered got %0b want %0b",
                                          rsp_payload.was_filtered, oldest_pixel.was_filtered));
            end
            results_seen++;
         end
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      sgpf_pkg::pixel_req_type px;
      int                      phase;
      int                      n;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      rsp_ready   = 1'b0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      cfg_filter  = sgpf_pkg::FILTER_SEPIA;
      cfg_color   = 1'b1;
      cfg_max     = 8'd255;
      cfg_left    = '0;
      cfg_right   = sgpf_pkg::BOUND_W'(sgpf_pkg::MAX_DIM);
      cfg_top     = '0;
      cfg_bottom  = sgpf_pkg::BOUND_W'(sgpf_pkg::MAX_DIM);

      stim_table.push_back(known_row(0, 0, 0, 0, 0, 0, 0, 0, 1));
      stim_table.push_back(known_row(255, 255, 255, 4095, 4095, 255, 255, 239, 1));
      stim_table.push_back(pixel_row(255, 0, 0, 0, 4095));
      stim_table.push_back(pixel_row(0, 255, 0, 4095, 0));
      stim_table.push_back(pixel_row(0, 0, 255, 1234, 567));
      stim_table.push_back(pixel_row(170, 85, 170, 'hAAA, 'h555));
      stim_table.push_back(pixel_row(85, 170, 85, 'h555, 'hAAA));
      stim_table.push_back(csr_row(sgpf_pkg::CSR_MAX_LEVEL, 0));
      stim_table.push_back(known_row(200, 100, 50, 10, 10, 0, 0, 0, 1));
      stim_table.push_back(csr_row(sgpf_pkg::CSR_MAX_LEVEL, 100));
      stim_table.push_back(known_row(255, 255, 255, 20, 30, 100, 100, 100, 1));
      stim_table.push_back(csr_row(sgpf_pkg::CSR_FILTER_KIND, sgpf_pkg::FILTER_GRAY));
      stim_table.push_back(known_row(255, 255, 255, 40, 50, 255, 255, 255, 1));
      stim_table.push_back(known_row(1, 1, 0, 60, 70, 0, 0, 0, 1));
      stim_table.push_back(pixel_row(10, 20, 31, 80, 90));
      stim_table.push_back(csr_row(sgpf_pkg::CSR_IMAGE_IS_COLOR, 0));
      stim_table.push_back(known_row(12, 34, 56, 7, 8, 12, 34, 56, 0));
      stim_table.push_back(csr_row(sgpf_pkg::CSR_IMAGE_IS_COLOR, 1));
      stim_table.push_back(csr_row(sgpf_pkg::CSR_SEL_LEFT, 100));
      stim_table.push_back(csr_row(sgpf_pkg::CSR_SEL_RIGHT, 200));
      stim_table.push_back(csr_row(sgpf_pkg::CSR_SEL_TOP, 50));
      stim_table.push_back(csr_row(sgpf_pkg::CSR_SEL_BOTTOM, 60));
      stim_table.push_back(pixel_row(90, 180, 45, 100, 50));
      stim_table.push_back(pixel_row(33, 66, 99, 199, 59));
      stim_table.push_back(known_row(90, 80, 70, 200, 55, 90, 80, 70, 0));
      stim_table.push_back(known_row(90, 80, 70, 99, 55, 90, 80, 70, 0));
      stim_table.push_back(known_row(90, 80, 70, 150, 60, 90, 80, 70, 0));
      stim_table.push_back(known_row(90, 80, 70, 150, 49, 90, 80, 70, 0));
      stim_table.push_back(csr_row(sgpf_pkg::CSR_SEL_RIGHT, 100));
      stim_table.push_back(known_row(5, 6, 7, 100, 55, 5, 6, 7, 0));
      stim_table.push_back(csr_row(CSR_SPARE_IDX, 'h1FFF));
      stim_table.push_back(known_row(5, 6, 7, 100, 55, 5, 6, 7, 0));
      stim_table.push_back(csr_row(sgpf_pkg::CSR_SEL_LEFT, 0));
      stim_table.push_back(csr_row(sgpf_pkg::CSR_SEL_RIGHT, sgpf_pkg::MAX_DIM));
      stim_table.push_back(csr_row(sgpf_pkg::CSR_SEL_TOP, 60));
      stim_table.push_back(known_row(8, 9, 10, 0, 59, 8, 9, 10, 0));
      stim_table.push_back(csr_row(sgpf_pkg::CSR_SEL_TOP, 0));
      stim_table.push_back(csr_row(sgpf_pkg::CSR_SEL_BOTTOM, sgpf_pkg::MAX_DIM));
      stim_table.push_back(csr_row(sgpf_pkg::CSR_FILTER_KIND, sgpf_pkg::FILTER_SEPIA));
      stim_table.push_back(csr_row(sgpf_pkg::CSR_MAX_LEVEL, 255));
      stim_table.push_back(pixel_row(1, 2, 3, 4095, 0));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) begin
         if (stim_table[i].kind == ROW_CSR)
            write_csr(stim_table[i].idx, stim_table[i].data);
         else
            send_pixel(stim_table[i].px, stim_table[i].known, stim_table[i].want);
      end

      for (phase = 0; phase < 4; phase++) begin
         send_idle_pct  = send_pcts[phase];
         recv_stall_pct = stall_pcts[phase];
         shuffle_settings();
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 60 == 59) shuffle_settings();
            if (n == 100) hold_requests <= hold_requests + 1;
            if (n == 200) wait_for_results();
            px.red_in    = pick_sample();
            px.green_in  = pick_sample();
            px.blue_in   = pick_sample();
            px.pixel_col = pick_coord(cfg_left, cfg_right);
            px.pixel_row = pick_coord(cfg_top, cfg_bottom);
            send_pixel(px, 1'b0, '0);
         end
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/sgpf_pkg.sv
hdl/sepia_grayscale_pixel_filter_unit.sv
sim/tb.sv
